[rtl/clhm_pkg.sv]
// ----------------------------------------------------------------------------
// clhm_pkg
// Shared constants, types and helpers of the color level histogram mapper.
// ----------------------------------------------------------------------------
package clhm_pkg;

  // histogram geometry
  localparam int MAX_LEVELS  = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int LEVEL_AW    = $clog2(MAX_LEVELS);

  // pixel channels
  localparam int PIX_W   = 8;
  localparam int NUM_CH  = 3;
  localparam int CH_W    = $clog2(NUM_CH);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  localparam logic [PIX_W-1:0] FULL_SCALE = {PIX_W{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // shared divider: one quotient bit per step
  localparam int DIV_STEPS = PIX_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_LEVELS = 2'd0;
  localparam logic [1:0] REG_BRIGHT = 2'd1;
  localparam logic [1:0] REG_DARK   = 2'd2;

  localparam logic [PIX_W-1:0] LEVELS_RST = 8'd8;
  localparam logic [PIX_W-1:0] BRIGHT_RST = 8'd32;
  localparam logic [PIX_W-1:0] DARK_RST   = 8'd20;

  typedef enum logic [1:0] {
    MODE_ACC  = 2'd0,
    MODE_MAP  = 2'd1,
    MODE_CLR  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_INDEX,
    ST_READ,
    ST_UPDATE,
    ST_FREQ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [PIX_W-1:0] level_count;
    logic [PIX_W-1:0] bright_offset;
    logic [PIX_W-1:0] dark_offset;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] num_hi;
    logic [PIX_W-1:0]       num_lo;
    logic [COUNT_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quo;
  } div_rsp_t;

  // saturating count increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] r;
    r = (c == CNT_MAX) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

[rtl/clhm_div.sv]
// ----------------------------------------------------------------------------
// clhm_div
// Shared restoring divider, one quotient bit per cycle, 8-bit quotient.
// A quotient that does not fit in 8 bits saturates to all ones.
// ----------------------------------------------------------------------------
module clhm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clhm_pkg::div_req_t  req_i,
  output clhm_pkg::div_rsp_t  rsp_o
);
  import clhm_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIV_CW-1:0]      cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] den_q, den_d;
  logic [PIX_W-1:0]       lo_q, lo_d;
  logic [PIX_W-1:0]       quo_q, quo_d;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fit;

  // one trial subtraction per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    trial  = {rem_q, lo_q[PIX_W-1]};
    diff   = trial - {1'b0, den_q};
    fit    = (trial >= {1'b0, den_q});
    if (req_i.start) begin
      rem_d  = req_i.num_hi;
      lo_d   = req_i.num_lo;
      den_d  = req_i.den;
      ovf_d  = (req_i.num_hi >= req_i.den);
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      lo_d  = {lo_q[PIX_W-2:0], 1'b0};
      quo_d = {quo_q[PIX_W-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = ovf_q ? FULL_SCALE : quo_q;

endmodule

[rtl/clhm_ram.sv]
// ----------------------------------------------------------------------------
// clhm_ram
// Level count memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clhm_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [clhm_pkg::LEVEL_AW-1:0]    waddr_i,
  input  logic [clhm_pkg::COUNT_WIDTH-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [clhm_pkg::LEVEL_AW-1:0]    raddr_i,
  output logic [clhm_pkg::COUNT_WIDTH-1:0] rdata_o
);
  import clhm_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [MAX_LEVELS];
  logic [COUNT_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/clhm_cfg.sv]
// ----------------------------------------------------------------------------
// clhm_cfg
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module clhm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clhm_pkg::PADDR_W-1:0] paddr,
  input  logic [clhm_pkg::PDATA_W-1:0] pwdata,
  output logic [clhm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output clhm_pkg::cfg_t               cfg_o
);
  import clhm_pkg::*;

  logic             wr;
  logic [1:0]       reg_idx;
  logic [PIX_W-1:0] levels_q, bright_q, dark_q;

  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LEVELS_RST;
      bright_q <= BRIGHT_RST;
      dark_q   <= DARK_RST;
    end else if (wr) begin
      unique case (reg_idx)
        REG_LEVELS: levels_q <= pwdata[PIX_W-1:0];
        REG_BRIGHT: bright_q <= pwdata[PIX_W-1:0];
        REG_DARK:   dark_q   <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_LEVELS: prdata = PDATA_W'(levels_q);
      REG_BRIGHT: prdata = PDATA_W'(bright_q);
      REG_DARK:   prdata = PDATA_W'(dark_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.level_count   = levels_q;
  assign cfg_o.bright_offset = bright_q;
  assign cfg_o.dark_offset   = dark_q;

endmodule

[rtl/color_level_histogram_mapper.sv]
// ----------------------------------------------------------------------------
// color_level_histogram_mapper
// Per-pixel brighten, darken and level quantize of a BGR pixel, with a
// per-channel level histogram that is accumulated, mapped or cleared.
// ----------------------------------------------------------------------------
// Accumulate and map items run the shared 8-step divider for the level step,
// then for each channel's level index; a map item on a non-empty histogram
// then divides each channel's scaled count by the pixel total. A new item is
// taken only once the last result is loaded; clear and unused items give none.
// Reset: registers take their defaults, then a clearing pass zeroes the
// histograms while in_stall_o stays high.
module color_level_histogram_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clhm_pkg::PADDR_W-1:0] paddr,
  input  logic [clhm_pkg::PDATA_W-1:0] pwdata,
  output logic [clhm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // input item
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic [7:0]                   blue_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   red_in_i,
  // result item
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   blue_brighter_o,
  output logic [7:0]                   green_brighter_o,
  output logic [7:0]                   red_brighter_o,
  output logic [7:0]                   blue_darker_o,
  output logic [7:0]                   green_darker_o,
  output logic [7:0]                   red_darker_o,
  output logic [7:0]                   blue_quantized_o,
  output logic [7:0]                   green_quantized_o,
  output logic [7:0]                   red_quantized_o,
  output logic [7:0]                   blue_frequency_o,
  output logic [7:0]                   green_frequency_o,
  output logic [7:0]                   red_frequency_o
);
  import clhm_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e                 state_q, state_d;
  logic [CH_W-1:0]        ch_q, ch_d;
  logic                   div_act_q, div_act_d;
  logic [LEVEL_AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic                   out_valid_q, out_valid_d;

  mode_e                  mode_q;
  logic [PIX_W-1:0]       pix_q [NUM_CH];
  logic [PIX_W-1:0]       pix_in [NUM_CH];
  logic [PIX_W-1:0]       nlev_q, nlev_in, lev_raw;
  logic [PIX_W-1:0]       step_q, step_d;
  logic [PIX_W-1:0]       idx_q [NUM_CH];
  logic [PIX_W-1:0]       idx_d [NUM_CH];
  logic [PIX_W-1:0]       freq_q [NUM_CH];
  logic [PIX_W-1:0]       freq_d [NUM_CH];
  logic                   load_in;
  logic                   out_load;

  logic                   ram_we, ram_re;
  logic [COUNT_WIDTH-1:0] rd_cnt [NUM_CH];
  logic [COUNT_WIDTH+PIX_W-1:0] scaled;

  logic [PIX_W-1:0]       brt [NUM_CH];
  logic [PIX_W-1:0]       drk [NUM_CH];
  logic [PIX_W-1:0]       qnt [NUM_CH];
  logic [PIX_W:0]         bsum [NUM_CH];
  logic [2*PIX_W-1:0]     prod [NUM_CH];
  logic [PIX_W-1:0]       out_brt_q [NUM_CH];
  logic [PIX_W-1:0]       out_drk_q [NUM_CH];
  logic [PIX_W-1:0]       out_qnt_q [NUM_CH];
  logic [PIX_W-1:0]       out_frq_q [NUM_CH];

  // configuration registers
  clhm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared divider
  clhm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // one count memory per channel
  for (genvar k = 0; k < NUM_CH; k++) begin : g_ram
    clhm_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i ((state_q == ST_CLEAR) ? clr_cnt_q : idx_q[k][LEVEL_AW-1:0]),
      .wdata_i ((state_q == ST_CLEAR) ? '0 : sat_inc(rd_cnt[k])),
      .re_i    (ram_re),
      .raddr_i (idx_q[k][LEVEL_AW-1:0]),
      .rdata_o (rd_cnt[k])
    );
  end

  // input channel order and effective level count
  assign pix_in[0] = blue_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = red_in_i;
  assign lev_raw   = (cfg.level_count == '0) ? PIX_W'(1) : cfg.level_count;
  assign nlev_in   = ({1'b0, lev_raw} > (PIX_W+1)'(MAX_LEVELS)) ?
                     PIX_W'(MAX_LEVELS) : lev_raw;

  // count times full scale, as (count << 8) - count
  assign scaled = {rd_cnt[ch_q], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, rd_cnt[ch_q]};

  // divider operands by phase
  always_comb begin
    div_req.start  = 1'b0;
    div_req.num_hi = '0;
    div_req.num_lo = FULL_SCALE;
    div_req.den    = COUNT_WIDTH'(nlev_q);
    unique case (state_q)
      ST_INDEX: begin
        div_req.num_lo = pix_q[ch_q];
        div_req.den    = COUNT_WIDTH'(step_q);
      end
      ST_FREQ: begin
        div_req.num_hi = scaled[COUNT_WIDTH+PIX_W-1:PIX_W];
        div_req.num_lo = scaled[PIX_W-1:0];
        div_req.den    = total_q;
      end
      default: ;
    endcase
    if ((state_q == ST_STEP || state_q == ST_INDEX || state_q == ST_FREQ) && !div_act_q) begin
      div_req.start = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    div_act_d = div_act_q;
    clr_cnt_d = clr_cnt_q;
    total_d   = total_q;
    step_d    = step_q;
    idx_d     = idx_q;
    freq_d    = freq_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_in   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        total_d   = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LEVEL_AW'(MAX_LEVELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_CLR: begin
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            MODE_ACC, MODE_MAP: begin
              div_act_d = 1'b0;
              state_d   = ST_STEP;
            end
            MODE_NONE: ;
          endcase
        end
      end
      ST_STEP: begin
        if (!div_act_q) begin
          div_act_d = 1'b1;
        end else if (div_rsp.done) begin
          step_d    = (div_rsp.quo == '0) ? PIX_W'(1) : div_rsp.quo;
          div_act_d = 1'b0;
          ch_d      = '0;
          state_d   = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (!div_act_q) begin
          div_act_d = 1'b1;
        end else if (div_rsp.done) begin
          // top of range clamps to the last level
          idx_d[ch_q] = (div_rsp.quo > nlev_q - 1'b1) ? nlev_q - 1'b1 : div_rsp.quo;
          div_act_d   = 1'b0;
          if (ch_q == LAST_CH) begin
            ch_d    = '0;
            state_d = ST_READ;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (mode_q == MODE_ACC) begin
          ram_we  = 1'b1;
          total_d = sat_inc(total_q);
          for (int k = 0; k < NUM_CH; k++) freq_d[k] = '0;
          state_d = ST_OUT;
        end else if (total_q == '0) begin
          // empty histogram maps to zero
          for (int k = 0; k < NUM_CH; k++) freq_d[k] = '0;
          state_d = ST_OUT;
        end else begin
          ch_d      = '0;
          div_act_d = 1'b0;
          state_d   = ST_FREQ;
        end
      end
      ST_FREQ: begin
        if (!div_act_q) begin
          div_act_d = 1'b1;
        end else if (div_rsp.done) begin
          freq_d[ch_q] = div_rsp.quo;
          div_act_d    = 1'b0;
          if (ch_q == LAST_CH) begin
            ch_d    = '0;
            state_d = ST_OUT;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ch_q        <= '0;
      div_act_q   <= 1'b0;
      clr_cnt_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      div_act_q   <= div_act_d;
      clr_cnt_q   <= clr_cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item capture and working values
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      mode_q <= mode_e'(mode_i);
      pix_q  <= pix_in;
      nlev_q <= nlev_in;
    end
    step_q <= step_d;
    idx_q  <= idx_d;
    freq_q <= freq_d;
  end

  // per-channel result arithmetic
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      bsum[k] = {1'b0, pix_q[k]} + {1'b0, cfg.bright_offset};
      brt[k]  = bsum[k][PIX_W] ? FULL_SCALE : bsum[k][PIX_W-1:0];
      drk[k]  = (pix_q[k] > cfg.dark_offset) ? pix_q[k] - cfg.dark_offset : '0;
      prod[k] = idx_q[k] * step_q;
      qnt[k]  = (prod[k] > (2*PIX_W)'(FULL_SCALE)) ? FULL_SCALE : prod[k][PIX_W-1:0];
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_brt_q <= brt;
      out_drk_q <= drk;
      out_qnt_q <= qnt;
      out_frq_q <= freq_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign blue_brighter_o   = out_brt_q[0];
  assign green_brighter_o  = out_brt_q[1];
  assign red_brighter_o    = out_brt_q[2];
  assign blue_darker_o     = out_drk_q[0];
  assign green_darker_o    = out_drk_q[1];
  assign red_darker_o      = out_drk_q[2];
  assign blue_quantized_o  = out_qnt_q[0];
  assign green_quantized_o = out_qnt_q[1];
  assign red_quantized_o   = out_qnt_q[2];
  assign blue_frequency_o  = out_frq_q[0];
  assign green_frequency_o = out_frq_q[1];
  assign red_frequency_o   = out_frq_q[2];

  // checks
  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> total_q == '0)
    else $error("pixel total not cleared by clearing pass");

  a_we_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_UPDATE && mode_q == MODE_ACC))
    else $error("count memory written outside clear or accumulate");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INDEX |-> step_q != '0)
    else $error("level step is zero");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FREQ |-> rd_cnt[ch_q] <= total_q)
    else $error("level count exceeds pixel total");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> idx_q[0] < nlev_q && idx_q[1] < nlev_q && idx_q[2] < nlev_q)
    else $error("level index out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

endmodule
